### sv/assert_macros.svh
// Assertion macros shared by the steering unit RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AST_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/pts_pkg.sv
// Types, constants, microcode table and helper functions of the steering unit.
// Depends on nothing; used by pivot_then_drive_steering_unit.
package pts_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int EXT_W       = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PC_W        = 4;
	localparam int DIV_W       = 16;

	localparam logic [7:0] PIVOT_POWER_RST = 8'd50;
	localparam logic [7:0] START_POWER_RST = 8'd50;
	localparam logic [7:0] POWER_STEP_RST  = 8'd5;
	localparam logic [6:0] ANGLE_TOL_RST   = 7'd5;

	typedef enum logic [1:0] {
		PH_DONE  = 2'd0,
		PH_TURN  = 2'd1,
		PH_DRIVE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		DIR_HALT = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BACK = 2'd2
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_CIRC  = 3'd0,
		REG_COUNTS_REV  = 3'd1,
		REG_PIVOT_POWER = 3'd2,
		REG_START_POWER = 3'd3,
		REG_POWER_STEP  = 3'd4,
		REG_ANGLE_TOL   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_START_INIT,
		OP_DIV_STEP,
		OP_MUL,
		OP_GOAL,
		OP_START_OUT,
		OP_TURN_CHECK,
		OP_RUN_CMP,
		OP_LEVEL,
		OP_DRIVE_OUT,
		OP_IDLE_OUT,
		OP_HALT_OUT
	} uop_t;

	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_DIV_MORE,
		CND_NOT_DRIVE,
		CND_NOT_RUN
	} cond_t;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            fin;
	} ucw_t;

	// Program entry points and jump targets
	localparam logic [PC_W-1:0] S_INIT   = 4'd0;
	localparam logic [PC_W-1:0] S_DIV    = 4'd1;
	localparam logic [PC_W-1:0] S_MUL    = 4'd2;
	localparam logic [PC_W-1:0] S_GOAL   = 4'd3;
	localparam logic [PC_W-1:0] S_OUT    = 4'd4;
	localparam logic [PC_W-1:0] T_CHK    = 4'd5;
	localparam logic [PC_W-1:0] T_ROUTE  = 4'd6;
	localparam logic [PC_W-1:0] D_CMP    = 4'd7;
	localparam logic [PC_W-1:0] D_BR     = 4'd8;
	localparam logic [PC_W-1:0] D_LEV    = 4'd9;
	localparam logic [PC_W-1:0] D_OUT    = 4'd10;
	localparam logic [PC_W-1:0] T_OTHER  = 4'd11;
	localparam logic [PC_W-1:0] D_HALT   = 4'd12;

	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{op: OP_NOP, cond: CND_NEVER, target: S_INIT, fin: 1'b1};
		case (pc)
			S_INIT:  w = '{op: OP_START_INIT, cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			S_DIV:   w = '{op: OP_DIV_STEP,   cond: CND_DIV_MORE,  target: S_DIV,   fin: 1'b0};
			S_MUL:   w = '{op: OP_MUL,        cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			S_GOAL:  w = '{op: OP_GOAL,       cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			S_OUT:   w = '{op: OP_START_OUT,  cond: CND_NEVER,     target: S_INIT,  fin: 1'b1};
			T_CHK:   w = '{op: OP_TURN_CHECK, cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			T_ROUTE: w = '{op: OP_NOP,        cond: CND_NOT_DRIVE, target: T_OTHER, fin: 1'b0};
			D_CMP:   w = '{op: OP_RUN_CMP,    cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			D_BR:    w = '{op: OP_NOP,        cond: CND_NOT_RUN,   target: D_HALT,  fin: 1'b0};
			D_LEV:   w = '{op: OP_LEVEL,      cond: CND_NEVER,     target: S_INIT,  fin: 1'b0};
			D_OUT:   w = '{op: OP_DRIVE_OUT,  cond: CND_NEVER,     target: S_INIT,  fin: 1'b1};
			T_OTHER: w = '{op: OP_IDLE_OUT,   cond: CND_NEVER,     target: S_INIT,  fin: 1'b1};
			D_HALT:  w = '{op: OP_HALT_OUT,   cond: CND_NEVER,     target: S_INIT,  fin: 1'b1};
			default: w = '{op: OP_NOP,        cond: CND_NEVER,     target: S_INIT,  fin: 1'b1};
		endcase
		return w;
	endfunction

	// Clamp a level that has been moved by one power step to 0..255.
	function automatic logic [7:0] sat_level(input logic signed [9:0] v);
		logic [7:0] r;
		if (v[9])
			r = 8'd0;
		else if (v[8])
			r = 8'd255;
		else
			r = v[7:0];
		return r;
	endfunction

	function automatic logic [7:0] mag8(input logic signed [7:0] v);
		return v[7] ? (~v + 8'd1) : v;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] mag_cnt(input logic signed [COUNT_WIDTH-1:0] v);
		return v[COUNT_WIDTH-1] ? ((~v) + {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) : v;
	endfunction

	// Add a wheel delta to a total, clamped to the signed count range.
	function automatic logic signed [COUNT_WIDTH-1:0] sat_add(
		input logic signed [COUNT_WIDTH-1:0] t,
		input logic signed [7:0]             d
	);
		logic [COUNT_WIDTH:0]         s;
		logic signed [COUNT_WIDTH-1:0] r;
		s = {t[COUNT_WIDTH-1], t} + {{(COUNT_WIDTH-7){d[7]}}, d};
		if (s[COUNT_WIDTH] != s[COUNT_WIDTH-1])
			r = {s[COUNT_WIDTH], {(COUNT_WIDTH-1){~s[COUNT_WIDTH]}}};
		else
			r = s[COUNT_WIDTH-1:0];
		return r;
	endfunction

endpackage

### sv/pivot_then_drive_steering_unit.sv
// Top level of the pivot-then-drive steering unit: microcode sequencer and datapath.
// Depends on pts_pkg and assert_macros.svh.

// A start transaction (op = 1) runs 20 program steps: one setup step, sixteen
// steps of a bit-serial restoring divider that forms distance /
// wheel_circumference, one multiply by counts_per_rev, one saturation step and
// the output step. A tick transaction (op = 0) runs 3 to 6 steps. In either
// case the next transaction can be accepted once the output step has run.
// Turning ticks that stay outside the heading window and ticks while done take
// 3 steps. A driving tick that reaches the goal and halts takes 5. A driving
// tick that keeps going takes 6. The step counter walks a 13-word control
// program; one item is worked on at a time and in_stall is high while it runs.
// A finished result sits in the output register; the next transaction is
// accepted while it waits, and that item holds at its output step until the
// register frees up, which adds the cycles of the output stall. Configuration
// writes are meant for idle periods only.
`include "assert_macros.svh"

module pivot_then_drive_steering_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic signed [15:0]             distance,
	input  logic signed [8:0]              target_heading,
	input  logic signed [8:0]              heading,
	input  logic signed [7:0]              left_delta,
	input  logic signed [7:0]              right_delta,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     left_dir,
	output logic [7:0]                     left_drive,
	output logic [1:0]                     right_dir,
	output logic [7:0]                     right_drive,
	output logic [1:0]                     phase
);

	localparam int CW = pts_pkg::COUNT_WIDTH;

	// configuration registers
	logic [15:0] circ_q, cpr_q;
	logic [7:0]  pivot_pwr_q, start_pwr_q, step_q;
	logic [6:0]  tol_q;

	// sequencer
	logic                     busy_q;
	logic [pts_pkg::PC_W-1:0] pc_q;
	pts_pkg::ucw_t            ucw;
	logic                     in_acc, out_blocked, exec, cond_hit;

	// captured item
	logic signed [15:0] distance_q;
	logic signed [8:0]  target_heading_q, heading_q;
	logic signed [7:0]  left_delta_q, right_delta_q;

	// architectural state
	pts_pkg::phase_t          phase_q;
	logic signed [8:0]        gh_q;
	logic [CW-1:0]            goal_q;
	logic signed [CW-1:0]     lt_q, rt_q;
	logic signed [7:0]        ll_q, rl_q;
	logic [7:0]               lvl_l_q, lvl_r_q;
	logic                     run_q;

	// divider and multiplier working registers
	logic [pts_pkg::DIV_W-1:0] quo_q, rem_q;
	logic [3:0]                cnt_q;
	logic                      neg_q;
	logic [31:0]               prod_q;

	// output register
	logic       out_valid_q;
	logic [1:0] left_dir_q, right_dir_q, phase_out_q;
	logic [7:0] left_drive_q, right_drive_q;

	// combinational datapath terms
	logic [15:0]            divisor, dist_mag;
	logic [16:0]            div_trial, div_diff;
	logic                   div_ge;
	logic [pts_pkg::EXT_W-1:0] prod_ext, goal_lim;
	logic signed [10:0]     win_hi, win_lo, hd_ext;
	logic                   in_win;
	logic [7:0]             la, ra;
	logic signed [9:0]      l_up, l_dn, r_up, r_dn;

	// next output command
	logic [1:0] left_dir_n, right_dir_n, phase_n;
	logic [7:0] left_drive_n, right_drive_n;

	assign in_stall    = busy_q;
	assign in_acc      = in_valid && !busy_q;
	assign out_blocked = out_valid_q && out_stall;
	assign ucw         = pts_pkg::ucode(pc_q);
	// hold an output step while the previous result has not been taken
	assign exec        = busy_q && !(ucw.fin && out_blocked);

	assign out_valid   = out_valid_q;
	assign left_dir    = left_dir_q;
	assign left_drive  = left_drive_q;
	assign right_dir   = right_dir_q;
	assign right_drive = right_drive_q;
	assign phase       = phase_out_q;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q      <= 16'd1;
			cpr_q       <= 16'd1;
			pivot_pwr_q <= pts_pkg::PIVOT_POWER_RST;
			start_pwr_q <= pts_pkg::START_POWER_RST;
			step_q      <= pts_pkg::POWER_STEP_RST;
			tol_q       <= pts_pkg::ANGLE_TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pts_pkg::REG_WHEEL_CIRC:  circ_q      <= cfg_data;
				pts_pkg::REG_COUNTS_REV:  cpr_q       <= cfg_data;
				pts_pkg::REG_PIVOT_POWER: pivot_pwr_q <= cfg_data[7:0];
				pts_pkg::REG_START_POWER: start_pwr_q <= cfg_data[7:0];
				pts_pkg::REG_POWER_STEP:  step_q      <= cfg_data[7:0];
				pts_pkg::REG_ANGLE_TOL:   tol_q       <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Jump condition of the current control word.
	always_comb begin
		case (ucw.cond)
			pts_pkg::CND_NEVER:     cond_hit = 1'b0;
			pts_pkg::CND_ALWAYS:    cond_hit = 1'b1;
			pts_pkg::CND_DIV_MORE:  cond_hit = (cnt_q != 4'd15);
			pts_pkg::CND_NOT_DRIVE: cond_hit = (phase_q != pts_pkg::PH_DRIVE);
			pts_pkg::CND_NOT_RUN:   cond_hit = !run_q;
			default:                cond_hit = 1'b0;
		endcase
	end

	// Step counter: enter the start or tick program on acceptance, advance or
	// jump while running, drop out after the final step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= pts_pkg::S_INIT;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			pc_q   <= op ? pts_pkg::S_INIT : pts_pkg::T_CHK;
		end else if (exec) begin
			if (ucw.fin)
				busy_q <= 1'b0;
			pc_q <= cond_hit ? ucw.target : (pc_q + 4'd1);
		end
	end

	// Capture the item fields; they are read by later steps.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			distance_q       <= distance;
			target_heading_q <= target_heading;
			heading_q        <= heading;
			left_delta_q     <= left_delta;
			right_delta_q    <= right_delta;
		end
	end

	// Datapath terms.
	always_comb begin
		divisor   = (circ_q == 16'd0) ? 16'd1 : circ_q;
		dist_mag  = distance_q[15] ? (~distance_q + 16'd1) : distance_q;
		div_trial = {rem_q, quo_q[pts_pkg::DIV_W-1]};
		div_diff  = div_trial - {1'b0, divisor};
		div_ge    = (div_trial >= {1'b0, divisor});
		prod_ext  = {{(pts_pkg::EXT_W-32){1'b0}}, prod_q};
		// limit is the magnitude of the most negative or most positive count
		goal_lim  = {{(pts_pkg::EXT_W-CW){1'b0}}, neg_q, {(CW-1){~neg_q}}};
		hd_ext    = {{2{heading_q[8]}}, heading_q};
		win_hi    = {{2{gh_q[8]}}, gh_q} + {4'd0, tol_q};
		win_lo    = {{2{gh_q[8]}}, gh_q} - {4'd0, tol_q};
		in_win    = (hd_ext > win_lo) && (hd_ext < win_hi);
		la        = pts_pkg::mag8(ll_q);
		ra        = pts_pkg::mag8(rl_q);
		l_up      = {2'b00, lvl_l_q} + {2'b00, step_q};
		l_dn      = {2'b00, lvl_l_q} - {2'b00, step_q};
		r_up      = {2'b00, lvl_r_q} + {2'b00, step_q};
		r_dn      = {2'b00, lvl_r_q} - {2'b00, step_q};
	end

	// Architectural state, driven by the micro-operation of the current step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pts_pkg::PH_DONE;
			gh_q    <= 9'sd0;
			goal_q  <= '0;
			lt_q    <= '0;
			rt_q    <= '0;
			ll_q    <= 8'sd0;
			rl_q    <= 8'sd0;
			lvl_l_q <= pts_pkg::START_POWER_RST;
			lvl_r_q <= pts_pkg::START_POWER_RST;
			run_q   <= 1'b0;
		end else if (exec) begin
			case (ucw.op)
				pts_pkg::OP_START_INIT: begin
					gh_q    <= target_heading_q;
					lt_q    <= '0;
					rt_q    <= '0;
					ll_q    <= 8'sd0;
					rl_q    <= 8'sd0;
					lvl_l_q <= start_pwr_q;
					lvl_r_q <= start_pwr_q;
				end
				pts_pkg::OP_GOAL:
					goal_q <= (prod_ext > goal_lim) ? goal_lim[CW-1:0] : prod_ext[CW-1:0];
				pts_pkg::OP_START_OUT:
					phase_q <= (gh_q != 9'sd0) ? pts_pkg::PH_TURN : pts_pkg::PH_DRIVE;
				pts_pkg::OP_TURN_CHECK:
					if (phase_q == pts_pkg::PH_TURN && in_win)
						phase_q <= pts_pkg::PH_DRIVE;
				pts_pkg::OP_RUN_CMP:
					run_q <= (pts_pkg::mag_cnt(rt_q) < goal_q) ||
						(pts_pkg::mag_cnt(lt_q) < goal_q);
				pts_pkg::OP_LEVEL: begin
					// shift power toward the wheel that moved less last tick
					if (la > ra) begin
						lvl_l_q <= pts_pkg::sat_level(l_dn);
						lvl_r_q <= pts_pkg::sat_level(r_up);
					end else if (la < ra) begin
						lvl_l_q <= pts_pkg::sat_level(l_up);
						lvl_r_q <= pts_pkg::sat_level(r_dn);
					end
				end
				pts_pkg::OP_DRIVE_OUT: begin
					lt_q <= pts_pkg::sat_add(lt_q, left_delta_q);
					rt_q <= pts_pkg::sat_add(rt_q, right_delta_q);
					ll_q <= left_delta_q;
					rl_q <= right_delta_q;
				end
				pts_pkg::OP_HALT_OUT:
					phase_q <= pts_pkg::PH_DONE;
				default: ;
			endcase
		end
	end

	// Divider and multiplier working registers.
	always_ff @(posedge clk) begin
		if (exec) begin
			case (ucw.op)
				pts_pkg::OP_START_INIT: begin
					quo_q <= dist_mag;
					rem_q <= '0;
					cnt_q <= 4'd0;
					neg_q <= distance_q[15];
				end
				pts_pkg::OP_DIV_STEP: begin
					rem_q <= div_ge ? div_diff[15:0] : div_trial[15:0];
					quo_q <= {quo_q[pts_pkg::DIV_W-2:0], div_ge};
					cnt_q <= cnt_q + 4'd1;
				end
				pts_pkg::OP_MUL:
					prod_q <= {16'd0, quo_q} * {16'd0, cpr_q};
				default: ;
			endcase
		end
	end

	// Output register: load on the final step of each item, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && ucw.fin && ucw.op != pts_pkg::OP_NOP) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Motor command of the final step; default to a halt, the cases override it.
	always_comb begin
		left_dir_n    = pts_pkg::DIR_HALT;
		right_dir_n   = pts_pkg::DIR_HALT;
		left_drive_n  = pivot_pwr_q;
		right_drive_n = pivot_pwr_q;
		phase_n       = pts_pkg::PH_DONE;
		case (ucw.op)
			pts_pkg::OP_START_OUT: begin
				if (gh_q < 9'sd0) begin
					left_dir_n  = pts_pkg::DIR_FWD;
					right_dir_n = pts_pkg::DIR_BACK;
					phase_n     = pts_pkg::PH_TURN;
				end else if (gh_q > 9'sd0) begin
					left_dir_n  = pts_pkg::DIR_BACK;
					right_dir_n = pts_pkg::DIR_FWD;
					phase_n     = pts_pkg::PH_TURN;
				end else begin
					left_dir_n    = pts_pkg::DIR_FWD;
					right_dir_n   = pts_pkg::DIR_FWD;
					left_drive_n  = lvl_l_q;
					right_drive_n = lvl_r_q;
					phase_n       = pts_pkg::PH_DRIVE;
				end
			end
			pts_pkg::OP_DRIVE_OUT: begin
				left_dir_n    = pts_pkg::DIR_FWD;
				right_dir_n   = pts_pkg::DIR_FWD;
				left_drive_n  = lvl_l_q;
				right_drive_n = lvl_r_q;
				phase_n       = pts_pkg::PH_DRIVE;
			end
			pts_pkg::OP_IDLE_OUT: begin
				// repeat the pivot while turning; a tick while done just halts
				phase_n = phase_q;
				if (phase_q == pts_pkg::PH_TURN && gh_q < 9'sd0) begin
					left_dir_n  = pts_pkg::DIR_FWD;
					right_dir_n = pts_pkg::DIR_BACK;
				end else if (phase_q == pts_pkg::PH_TURN && gh_q > 9'sd0) begin
					left_dir_n  = pts_pkg::DIR_BACK;
					right_dir_n = pts_pkg::DIR_FWD;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec && ucw.fin) begin
			left_dir_q    <= left_dir_n;
			right_dir_q   <= right_dir_n;
			left_drive_q  <= left_drive_n;
			right_drive_q <= right_drive_n;
			phase_out_q   <= phase_n;
		end
	end

	`AST_NEXT(a_accept_starts, clk, arst_n, in_acc, busy_q, "accepted item did not start the program")
	`AST_NEXT(a_emit_holds, clk, arst_n, busy_q && ucw.fin && out_blocked, busy_q && $stable(pc_q), "output step advanced while result was waiting")
	`AST_SAME(a_turn_has_goal, clk, arst_n, phase_q == pts_pkg::PH_TURN && !busy_q, gh_q != 9'sd0, "turning with a zero goal heading")
	`AST_NEXT(a_fin_delivers, clk, arst_n, exec && ucw.fin, out_valid_q && !busy_q, "final step did not load the output register")

endmodule
